>>> hdl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_UPD
    } t_state;

    typedef struct packed {
        logic valid;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_cell_data;

    typedef struct packed {
        logic capture;
        logic shift;
    } t_cell_ctl;

endpackage

>>> hdl/lkvc_ifs.sv
// ----------------------------------------------------------------------------
// lkvc_ifs
// Request and response channels of the LRU key-value cache.
// ----------------------------------------------------------------------------
interface lkvc_req_if;
    logic valid;
    logic ready;
    logic req_type;
    logic signed [lkvc_pkg::KEY_W-1:0] lookup_key;
    logic signed [lkvc_pkg::VAL_W-1:0] write_value;

    modport source (output valid, req_type, lookup_key, write_value, input ready);
    modport sink (input valid, req_type, lookup_key, write_value, output ready);
endinterface

interface lkvc_rsp_if;
    logic valid;
    logic ready;
    logic hit;
    logic signed [lkvc_pkg::VAL_W-1:0] read_value;

    modport source (output valid, hit, read_value, input ready);
    modport sink (input valid, hit, read_value, output ready);
endinterface

>>> hdl/lkvc_cell.sv
// ----------------------------------------------------------------------------
// lkvc_cell
// One entry of the recency chain: holds a key, a value and a valid bit,
// registers its key match, and takes its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module lkvc_cell (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  lkvc_pkg::t_cell_ctl                    i_ctl,
    input  lkvc_pkg::t_cell_data                   i_prev,
    input  logic signed [lkvc_pkg::KEY_W-1:0]      i_key,
    output lkvc_pkg::t_cell_data                   o_data,
    output logic                                   o_match
);
    import lkvc_pkg::*;

    logic                    r_valid;
    logic signed [KEY_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_value;
    logic                    r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.shift) begin
                r_valid <= i_prev.valid;
            end
            if (i_ctl.capture) begin
                r_match <= r_valid && (r_key == i_key);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key   <= i_prev.key;
            r_value <= i_prev.value;
        end
    end

    assign o_data.valid = r_valid;
    assign o_data.key   = r_key;
    assign o_data.value = r_value;
    assign o_match      = r_match;

endmodule

>>> hdl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value store with least-recently-used replacement.
//
// The entries sit in a chain of cells kept in recency order: cell 0 is the
// most recent. A request is taken in the idle state, every cell compares its
// key with the request key in the next cycle and registers the match, and in
// the update state, once the response side can take the result, the chain
// shifts once: cells up to the hit cell, or up to the least recent or first
// free cell on a put miss, take their neighbor's entry and cell 0 takes the
// accessed entry. The response is registered with that shift, and no new
// request is taken until the item is done. A get miss leaves the chain as it
// is. The capacity register is read at each update, so a write takes effect
// from the next update.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]    i_cfg_wdata,
    lkvc_req_if.sink                      i_req,
    lkvc_rsp_if.source                    o_rsp
);
    import lkvc_pkg::*;

    localparam int W_OCC = $clog2(MAX_ENTRIES + 1);
    localparam int W_CMP = (W_OCC > CAP_W) ? W_OCC : CAP_W;

    t_state r_state;
    t_state n_state;

    logic [CAP_W-1:0]        r_cap;
    logic [W_OCC-1:0]        r_occ;
    logic [W_OCC-1:0]        n_occ;
    logic                    r_put;
    logic signed [KEY_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_wval;
    logic                    r_rsp_valid;
    logic                    r_rsp_hit;
    logic signed [VAL_W-1:0] r_rsp_value;

    t_cell_data              cell_data [MAX_ENTRIES];
    t_cell_data              cell_prev [MAX_ENTRIES];
    t_cell_ctl               cell_ctl  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]  match;

    logic                    fire;
    logic                    hit;
    logic signed [VAL_W-1:0] found_val;
    logic [W_CMP-1:0]        eff_cap;
    logic [W_CMP-1:0]        occ_ext;
    logic [W_CMP-1:0]        ins_pos;
    logic                    full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_W'(16);
            r_occ       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (fire) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_put  <= i_req.req_type;
            r_key  <= i_req.lookup_key;
            r_wval <= i_req.write_value;
        end
        if (fire) begin
            r_rsp_hit   <= hit;
            r_rsp_value <= (hit && !r_put) ? found_val : '0;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        fire        = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    fire    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        hit       = |match;
        found_val = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            found_val = found_val | (match[i] ? cell_data[i].value : '0);
        end
    end

    always_comb begin
        occ_ext = W_CMP'(r_occ);
        if (r_cap == '0) begin
            eff_cap = W_CMP'(1);
        end else if (W_CMP'(r_cap) > W_CMP'(MAX_ENTRIES)) begin
            eff_cap = W_CMP'(MAX_ENTRIES);
        end else begin
            eff_cap = W_CMP'(r_cap);
        end
        full    = (occ_ext >= eff_cap);
        ins_pos = full ? (occ_ext - W_CMP'(1)) : occ_ext;
        n_occ   = r_occ;
        if (fire && r_put && !hit && !full) begin
            n_occ = r_occ + W_OCC'(1);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            cell_ctl[i].capture = (r_state == S_LOOK);
            cell_ctl[i].shift   = fire && (hit ? (|(match >> i))
                                               : (r_put && (W_CMP'(i) <= ins_pos)));
            if (i == 0) begin
                cell_prev[i].valid = 1'b1;
                cell_prev[i].key   = r_key;
                cell_prev[i].value = r_put ? r_wval : found_val;
            end else begin
                cell_prev[i] = cell_data[(i == 0) ? 0 : i - 1];
            end
        end
    end

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        lkvc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl[g]),
            .i_prev  (cell_prev[g]),
            .i_key   (r_key),
            .o_data  (cell_data[g]),
            .o_match (match[g])
        );
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.hit        = r_rsp_hit;
    assign o_rsp.read_value = r_rsp_value;

endmodule

>>> sim/tb_lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Self-checking testbench for the LRU key-value cache. A clocked driver sends
// get and put requests from a queue and predicts each response on acceptance
// with its own LRU store model. A clocked monitor compares every response, in
// order, with the predictions. Directed requests cover the key and value
// extremes, hits, overwrites, evictions and the capacity corner cases.
// Random phases then run at several capacity settings, with random stalls on
// both channels and one stretch without any.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;

    import lkvc_pkg::*;

    localparam int SLOTS       = 16;
    localparam int KEY_POOL    = 24;
    localparam int PHASE_ITEMS = 125;
    localparam int TIMEOUT     = 200000;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_request;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } t_response;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;

    lkvc_req_if req_ch ();
    lkvc_rsp_if rsp_ch ();

    lru_key_value_cache #(
        .MAX_ENTRIES(SLOTS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    t_request    pending_requests[$];
    t_response   predicted_responses[$];
    logic [KEY_W-1:0] key_pool[KEY_POOL];

    logic [KEY_W-1:0] store_key[SLOTS];
    logic [VAL_W-1:0] store_val[SLOTS];
    bit               store_valid[SLOTS];
    int unsigned      store_rank[SLOTS];
    int unsigned      store_fill;
    logic [CAP_W-1:0] capacity_reg;

    bit steady;
    int error_count;
    int cycle_count;

    function automatic void promote_slot(int s);
        int unsigned old_rank;
        old_rank = store_valid[s] ? store_rank[s] : 32'hFFFF_FFFF;
        for (int i = 0; i < SLOTS; i++) begin
            if (i != s && store_valid[i] && store_rank[i] < old_rank) begin
                store_rank[i]++;
            end
        end
        store_rank[s] = 0;
    endfunction

    function automatic t_response cache_access(logic is_put, logic [KEY_W-1:0] key,
                                               logic [VAL_W-1:0] value);
        t_response   rsp;
        int          slot;
        bit          found;
        bit          have_lru;
        int unsigned worst;
        int unsigned limit;
        rsp = '0;
        slot = 0;
        found = 0;
        have_lru = 0;
        worst = 0;
        limit = capacity_reg;
        if (limit == 0) limit = 1;
        if (limit > SLOTS) limit = SLOTS;
        for (int i = 0; i < SLOTS; i++) begin
            if (!found && store_valid[i] && store_key[i] == key) begin
                found = 1;
                slot = i;
            end
        end
        if (found) begin
            rsp.hit = 1'b1;
            if (is_put == REQ_PUT) store_val[slot] = value;
            else rsp.read_value = store_val[slot];
            promote_slot(slot);
        end else if (is_put == REQ_PUT) begin
            if (store_fill >= limit) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (store_valid[i] && (!have_lru || store_rank[i] > worst)) begin
                        worst = store_rank[i];
                        slot = i;
                        have_lru = 1;
                    end
                end
                if (!have_lru) begin
                    slot = 0;
                    store_fill = 1;
                end
            end else begin
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (!store_valid[i]) slot = i;
                end
                store_fill++;
            end
            promote_slot(slot);
            store_key[slot] = key;
            store_val[slot] = value;
            store_valid[slot] = 1'b1;
        end
        return rsp;
    endfunction

    task automatic queue_request(logic kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        t_request req;
        req.req_type = kind;
        req.key = key;
        req.value = value;
        pending_requests.push_back(req);
    endtask

    task automatic queue_random_request();
        logic [KEY_W-1:0] key;
        case ($urandom_range(9))
            0: key = $urandom;
            1: key = key_pool[$urandom_range(3)];
            default: key = key_pool[$urandom_range(KEY_POOL - 1)];
        endcase
        queue_request(1'($urandom_range(1)), key, $urandom);
    endtask

    // Waits until every request has been sent and answered.
    task automatic drain();
        while (pending_requests.size() != 0 || req_ch.valid
               || predicted_responses.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        capacity_reg = cap;
        @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= TIMEOUT) begin
            $display("FAIL lru_key_value_cache");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_request nxt;
        bit       fire;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.req_type <= REQ_GET;
            req_ch.lookup_key <= '0;
            req_ch.write_value <= '0;
        end else begin
            fire = req_ch.valid && req_ch.ready;
            if (fire) begin
                predicted_responses.push_back(cache_access(req_ch.req_type,
                                                           req_ch.lookup_key,
                                                           req_ch.write_value));
            end
            if (!req_ch.valid || fire) begin
                if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 12)) begin
                    nxt = pending_requests.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.req_type <= nxt.req_type;
                    req_ch.lookup_key <= nxt.key;
                    req_ch.write_value <= nxt.value;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_response exp_rsp;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (predicted_responses.size() == 0) begin
                    $error("response with no request outstanding: hit %b read_value %h",
                           rsp_ch.hit, rsp_ch.read_value);
                    error_count++;
                end else begin
                    exp_rsp = predicted_responses.pop_front();
                    if (rsp_ch.hit !== exp_rsp.hit) begin
                        $error("hit: expected %b, actual %b", exp_rsp.hit, rsp_ch.hit);
                        error_count++;
                    end
                    if (rsp_ch.read_value !== exp_rsp.read_value) begin
                        $error("read_value: expected %h, actual %h",
                               exp_rsp.read_value, rsp_ch.read_value);
                        error_count++;
                    end
                end
            end
            rsp_ch.ready <= steady || ($urandom_range(99) >= 12);
        end
    end

    initial begin
        logic [CAP_W-1:0] phase_cap[8];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_GET;
        req_ch.lookup_key = '0;
        req_ch.write_value = '0;
        rsp_ch.ready = 1'b0;
        steady = 1'b0;
        error_count = 0;
        cycle_count = 0;
        for (int i = 0; i < SLOTS; i++) begin
            store_key[i] = '0;
            store_val[i] = '0;
            store_valid[i] = 1'b0;
            store_rank[i] = 0;
        end
        store_fill = 0;
        capacity_reg = 5'd16;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default capacity: misses, inserts with extreme keys and values, hits.
        queue_request(REQ_GET, 32'h0000_0000, 32'h5555_5555);
        queue_request(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_request(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_request(REQ_PUT, 32'h0000_0000, 32'h0000_0000);
        queue_request(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(REQ_GET, 32'h8000_0000, 32'hAAAA_AAAA);
        queue_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
        queue_request(REQ_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
        queue_request(REQ_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_request(REQ_PUT, 32'h0000_0011, 32'h0000_0005);
        queue_request(REQ_GET, 32'h0000_0022, 32'hDEAD_BEEF);
        drain();

        // Capacity lowered below the occupancy, so put misses replace the oldest.
        write_capacity(5'd2);
        queue_request(REQ_PUT, 32'h0000_000A, 32'h0000_00A0);
        queue_request(REQ_GET, 32'h8000_0000, 32'h0);
        queue_request(REQ_PUT, 32'h0000_000B, 32'h0000_00B0);
        queue_request(REQ_GET, 32'hFFFF_FFFF, 32'h0);
        queue_request(REQ_GET, 32'h0000_000A, 32'h0);
        drain();

        // A capacity of zero behaves as one.
        write_capacity(5'd0);
        queue_request(REQ_PUT, 32'h0000_000C, 32'h0000_00C0);
        queue_request(REQ_PUT, 32'h0000_000D, 32'h0000_00D0);
        queue_request(REQ_GET, 32'h0000_000C, 32'h0);
        queue_request(REQ_GET, 32'h0000_000D, 32'h0);
        drain();

        phase_cap[0] = 5'd31;
        phase_cap[1] = 5'd16;
        phase_cap[2] = 5'd1;
        phase_cap[3] = 5'd0;
        phase_cap[4] = 5'($urandom_range(2, 15));
        phase_cap[5] = 5'd4;
        phase_cap[6] = 5'd16;
        phase_cap[7] = 5'($urandom_range(17, 31));
        for (int p = 0; p < 8; p++) begin
            write_capacity(phase_cap[p]);
            steady = (p == 6);
            for (int n = 0; n < PHASE_ITEMS; n++) queue_random_request();
            drain();
        end

        if (error_count == 0) begin
            $display("PASS lru_key_value_cache");
        end else begin
            $display("FAIL lru_key_value_cache");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/lkvc_pkg.sv
hdl/lkvc_ifs.sv
hdl/lkvc_cell.sv
hdl/lru_key_value_cache.sv
sim/tb_lru_key_value_cache.sv
